### hw/rtl/swqt_pkg.sv
// ----------------------------------------------------------------------------
// swqt_pkg
// types and codes shared by the semaphore wait queue table
// ----------------------------------------------------------------------------
`default_nettype none

package swqt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TAKE   = 2'd2,
    OP_PEEK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] sem_key;
    logic [4:0]  proc_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] proc_out;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_ACT,
    S_UNLINK,
    S_OUT
  } state_e;

endpackage

`default_nettype wire

### hw/rtl/semaphore_wait_queue_table.sv
// ----------------------------------------------------------------------------
// semaphore_wait_queue_table
// table of semaphore descriptors, each owning a fifo of blocked processes
// ----------------------------------------------------------------------------
// usage: an item (op, sem_key, proc_id) enters on in_valid_i/in_ready_o; one
// result item (status, proc_out) leaves on out_valid_o/out_ready_i.
// one item at a time: in_ready_o is high only while the block is idle.
// out_valid_o rises after the descriptor search for every op that searches
// descriptors (insert, remove, peek, take-out); an insert of a blocked or
// out-of-range process, or a take-out of a process that is out of range or
// not blocked, answers straight from the check state without a search. the
// descriptor search compares one stored key per cycle through a single
// comparator and also notes the lowest free descriptor on the way. an item
// that searches passes through the check, scan, act, unlink and output states.
// the result waits in an output register until taken; a stalled receiver
// holds the block, which then takes no new item.
// of the tables, reset clears descriptor valid bits and blocked bits only; keys and links
// are written before they are read.
// ----------------------------------------------------------------------------
`default_nettype none

module semaphore_wait_queue_table
  import swqt_pkg::*;
#(
  parameter int MAX_PROCS = 32,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);

  state_e state_q, state_d;

  logic [MAX_PROCS-1:0] ent_valid_q;
  logic [MAX_PROCS-1:0] blocked_q;
  logic [KEY_WIDTH-1:0] ent_key_q  [MAX_PROCS];
  logic [IW-1:0]        head_q     [MAX_PROCS];
  logic [IW-1:0]        tail_q     [MAX_PROCS];
  logic [IW-1:0]        next_q     [MAX_PROCS];
  logic [IW-1:0]        prev_q     [MAX_PROCS];
  logic [KEY_WIDTH-1:0] wkey_q     [MAX_PROCS];

  logic [1:0]           op_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [4:0]           pid_q;
  logic [IW-1:0]        pix_q;
  logic [CW-1:0]        cnt_q;
  logic                 found_q, free_q;
  logic [IW-1:0]        fidx_q, freeidx_q;
  out_item_t            res_q;
  logic                 outv_q;

  logic [IW-1:0] cidx;
  logic          hit;
  logic          pid_ok;

  assign cidx   = cnt_q[IW-1:0];
  assign hit    = ent_valid_q[cidx] && (ent_key_q[cidx] == key_q);
  assign pid_ok = ({27'd0, pid_q} < 32'(MAX_PROCS));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_CHECK;
      S_CHECK:  begin
        if (op_q == OP_INSERT && (!pid_ok || blocked_q[pix_q])) state_d = S_OUT;
        else if (op_q == OP_TAKE && (!pid_ok || !blocked_q[pix_q])) state_d = S_OUT;
        else state_d = S_SCAN;
      end
      S_SCAN:   if (cnt_q == CW'(MAX_PROCS - 1)) state_d = S_ACT;
      S_ACT:    state_d = S_UNLINK;
      S_UNLINK: state_d = S_OUT;
      S_OUT:    if (out_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = outv_q;
    out_data_o  = res_q;
  end

  // unlink target (process p in descriptor d)
  logic [IW-1:0] ul_p, ul_pr, ul_nx;
  assign ul_p  = (op_q == OP_TAKE) ? pix_q : head_q[fidx_q];
  assign ul_pr = prev_q[ul_p];
  assign ul_nx = next_q[ul_p];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ent_valid_q <= '0;
      blocked_q   <= '0;
      outv_q      <= 1'b0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= in_data_i.op;
            key_q   <= KEY_WIDTH'(in_data_i.sem_key);
            pid_q   <= in_data_i.proc_id;
            pix_q   <= IW'(in_data_i.proc_id);
            cnt_q   <= '0;
            found_q <= 1'b0;
            free_q  <= 1'b0;
          end
        end
        S_CHECK: begin
          res_q.proc_out <= '0;
          if (op_q == OP_INSERT) begin
            res_q.status <= ST_FULL;
            if (!pid_ok || blocked_q[pix_q]) outv_q <= 1'b1;
          end else begin
            res_q.status <= ST_EMPTY;
            if (op_q == OP_TAKE) begin
              if (!pid_ok || !blocked_q[pix_q]) outv_q <= 1'b1;
              else key_q <= wkey_q[pix_q];
            end
          end
        end
        S_SCAN: begin
          if (!found_q && hit) begin
            found_q <= 1'b1;
            fidx_q  <= cidx;
          end
          if (!free_q && !ent_valid_q[cidx]) begin
            free_q    <= 1'b1;
            freeidx_q <= cidx;
          end
          cnt_q <= cnt_q + 1'b1;
        end
        S_ACT: begin
          if (op_q == OP_INSERT) begin
            if (found_q) begin
              next_q[tail_q[fidx_q]] <= pix_q;
              prev_q[pix_q]          <= tail_q[fidx_q];
              tail_q[fidx_q]         <= pix_q;
            end else if (free_q) begin
              ent_valid_q[freeidx_q] <= 1'b1;
              ent_key_q[freeidx_q]   <= key_q;
              head_q[freeidx_q]      <= pix_q;
              tail_q[freeidx_q]      <= pix_q;
            end
            if (found_q || free_q) begin
              blocked_q[pix_q] <= 1'b1;
              wkey_q[pix_q]    <= key_q;
              res_q.status     <= ST_OK;
              res_q.proc_out   <= pid_q;
            end
          end else if (found_q) begin
            res_q.status   <= ST_OK;
            res_q.proc_out <= 5'(ul_p);
          end
        end
        S_UNLINK: begin
          if (op_q != OP_INSERT && op_q != OP_PEEK && found_q) begin
            if (head_q[fidx_q] == ul_p && tail_q[fidx_q] == ul_p) begin
              ent_valid_q[fidx_q] <= 1'b0;
            end else if (head_q[fidx_q] == ul_p) begin
              head_q[fidx_q] <= ul_nx;
            end else if (tail_q[fidx_q] == ul_p) begin
              tail_q[fidx_q] <= ul_pr;
            end else begin
              next_q[ul_pr] <= ul_nx;
              prev_q[ul_nx] <= ul_pr;
            end
            blocked_q[ul_p] <= 1'b0;
          end
          outv_q <= 1'b1;
        end
        S_OUT: begin
          if (out_ready_i) outv_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outv_q |-> state_q == S_OUT) else $error("result shown outside output state");
  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.proc_out == 5'd0)
    else $error("nonzero process on failure");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while result pending");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> cnt_q < CW'(MAX_PROCS)) else $error("scan overrun");
`endif

endmodule

`default_nettype wire
